// ===== rtl/nsfs_pkg.sv =====
`default_nettype none

package nsfs_pkg;

  localparam int MAX_SENTENCE_LEN = 128;
  localparam int MAX_FIELD_NUMBER = 31;
  localparam int FIELD_CAP        = (MAX_FIELD_NUMBER < 31) ? MAX_FIELD_NUMBER : 31;

  localparam int LEN_W   = 8;
  localparam int FIELD_W = 5;
  localparam int POS_W   = 3;
  localparam int HDR_W   = 40;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;

  localparam logic [15:0] TALKER_GP = {CH_G, CH_P};
  localparam logic [HDR_W-1:0] HDR_GGA = {TALKER_GP, "GGA"};
  localparam logic [HDR_W-1:0] HDR_GLL = {TALKER_GP, "GLL"};
  localparam logic [HDR_W-1:0] HDR_GSA = {TALKER_GP, "GSA"};
  localparam logic [HDR_W-1:0] HDR_GSV = {TALKER_GP, "GSV"};
  localparam logic [HDR_W-1:0] HDR_VTG = {TALKER_GP, "VTG"};
  localparam logic [HDR_W-1:0] HDR_RMC = {TALKER_GP, "RMC"};

  localparam logic [POS_W-1:0] HDR_LAST = POS_W'(4);
  localparam logic [POS_W-1:0] HDR_FULL = POS_W'(5);

  typedef enum logic [2:0] {
    KIND_GGA  = 3'd0,
    KIND_GLL  = 3'd1,
    KIND_GSA  = 3'd2,
    KIND_GSV  = 3'd3,
    KIND_VTG  = 3'd4,
    KIND_RMC  = 3'd5,
    KIND_NONE = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t              sentence_kind;
    logic [FIELD_W-1:0] field_number;
    logic [7:0]         field_char;
    logic               char_valid;
    logic               field_done;
    logic               checksum_part;
    logic               sentence_done;
    logic               too_long;
  } res_t;

  function automatic kind_t header_kind(input logic [HDR_W-1:0] hdr);
    kind_t k;
    case (hdr)
      HDR_GGA: k = KIND_GGA;
      HDR_GLL: k = KIND_GLL;
      HDR_GSA: k = KIND_GSA;
      HDR_GSV: k = KIND_GSV;
      HDR_VTG: k = KIND_VTG;
      HDR_RMC: k = KIND_RMC;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [FIELD_W-1:0] next_field(input logic [FIELD_W-1:0] f);
    logic [FIELD_W-1:0] r;
    if (f < FIELD_W'(FIELD_CAP)) begin
      r = f + FIELD_W'(1);
    end else begin
      r = FIELD_W'(FIELD_CAP);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nsfs_ifs.sv =====
`default_nettype none

interface nsfs_byte_if import nsfs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfs_field_if import nsfs_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              sentence_kind;
  logic [FIELD_W-1:0] field_number;
  logic [7:0]         field_char;
  logic               char_valid;
  logic               field_done;
  logic               checksum_part;
  logic               sentence_done;
  logic               too_long;

  modport source (output valid, output sentence_kind, output field_number,
                  output field_char, output char_valid, output field_done,
                  output checksum_part, output sentence_done, output too_long,
                  input ready);
  modport sink   (input valid, input sentence_kind, input field_number,
                  input field_char, input char_valid, input field_done,
                  input checksum_part, input sentence_done, input too_long,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/nsfs_core.sv =====
`default_nettype none

module nsfs_core import nsfs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output res_t            res
);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [HDR_W-1:0]   letters_r, letters_nxt;
  kind_t              kind_r, kind_nxt;
  logic [FIELD_W-1:0] fc_r, fc_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;

  logic               term;
  logic               in_sent;
  logic [HDR_W-1:0]   hdr_word;
  kind_t              found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      letters_r <= '0;
      kind_r    <= KIND_NONE;
      fc_r      <= '0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      letters_r <= letters_nxt;
      kind_r    <= kind_nxt;
      fc_r      <= fc_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    letters_nxt = letters_r;
    kind_nxt    = kind_r;
    fc_nxt      = fc_r;
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;

    res.sentence_kind = KIND_NONE;
    res.field_number  = '0;
    res.field_char    = '0;
    res.char_valid    = 1'b0;
    res.field_done    = 1'b0;
    res.checksum_part = 1'b0;
    res.sentence_done = 1'b0;
    res.too_long      = 1'b0;

    term     = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    in_sent  = (phase_r == PH_BODY) || (phase_r == PH_CHECK);
    hdr_word = {letters_r[HDR_W-9:0], rx_byte};
    found    = header_kind(hdr_word);

    if (rx_byte == CH_DOLLAR) begin
      // restart, abandoning any sentence in progress
      phase_nxt   = PH_HEADER;
      pos_nxt     = '0;
      letters_nxt = '0;
      kind_nxt    = KIND_NONE;
      fc_nxt      = '0;
      len_nxt     = LEN_W'(1);
      ovf_nxt     = 1'b0;
    end else if (phase_r != PH_IDLE) begin
      if (!term && (len_r >= LEN_W'(MAX_SENTENCE_LEN))) begin
        // drop the byte, flag the sentence
        ovf_nxt = 1'b1;
        if (in_sent) begin
          res.sentence_kind = kind_r;
          res.field_number  = fc_r;
          res.checksum_part = (phase_r == PH_CHECK);
          res.too_long      = 1'b1;
        end
      end else begin
        if (!term && (len_r != '1)) begin
          len_nxt = len_r + LEN_W'(1);
        end
        if (phase_r == PH_HEADER) begin
          if (term) begin
            phase_nxt = PH_IDLE;
          end else begin
            letters_nxt = hdr_word;
            pos_nxt     = pos_r + POS_W'(1);
            if (pos_r >= HDR_LAST) begin
              pos_nxt   = HDR_FULL;
              phase_nxt = PH_IDLE;
              if (found != KIND_NONE) begin
                kind_nxt          = found;
                phase_nxt         = PH_BODY;
                fc_nxt            = '0;
                res.sentence_kind = found;
              end else begin
                res.sentence_kind = kind_r;
              end
            end
          end
        end else if ((phase_r == PH_BODY) && (fc_r == '0)) begin
          // the header must be followed by a comma
          if (rx_byte == CH_COMMA) begin
            fc_nxt            = FIELD_W'(1);
            res.sentence_kind = kind_r;
            res.too_long      = ovf_r;
          end else begin
            kind_nxt  = KIND_NONE;
            phase_nxt = PH_IDLE;
          end
        end else begin
          res.sentence_kind = kind_r;
          res.field_number  = fc_r;
          res.too_long      = ovf_r;
          res.checksum_part = (phase_r == PH_CHECK) && (rx_byte != CH_LF);
          if (rx_byte == CH_LF) begin
            res.sentence_done = 1'b1;
            phase_nxt         = PH_IDLE;
            kind_nxt          = KIND_NONE;
          end else if (rx_byte == CH_CR) begin
            res.field_done = 1'b1;
          end else if ((phase_r == PH_BODY) &&
                       ((rx_byte == CH_COMMA) || (rx_byte == CH_STAR))) begin
            res.field_done = 1'b1;
            fc_nxt         = next_field(fc_r);
            if (rx_byte == CH_STAR) begin
              phase_nxt = PH_CHECK;
            end
          end else begin
            res.char_valid = 1'b1;
            res.field_char = rx_byte;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nmea_sentence_field_splitter.sv =====
// Pipeline: a byte transferred in is held in the input register; its result is
//   registered in the result register when the pipeline advances and shown on the output.
// Throughput: one byte per cycle; the input register and result register form a
//   two-stage pipeline that stalls only when the output is not taken.
// Reset: synchronous, active low; parser returns to idle waiting for a dollar,
//   both stages are emptied.
`default_nettype none

module nmea_sentence_field_splitter import nsfs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  nsfs_byte_if.sink    in_rx,
  nsfs_field_if.source out_res
);

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       out_vld_r, out_vld_nxt;
  res_t       res_r;
  res_t       res;
  logic       advance;

  assign advance     = in_vld_r && (!out_vld_r || out_res.ready);
  assign in_rx.ready = !in_vld_r || advance;
  assign out_vld_nxt = advance || (out_vld_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rx.ready) begin
        in_vld_r <= in_rx.valid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rx.ready && in_rx.valid) begin
      byte_r <= in_rx.rx_byte;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  nsfs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (byte_r),
    .res     (res)
  );

  assign out_res.valid         = out_vld_r;
  assign out_res.sentence_kind = res_r.sentence_kind;
  assign out_res.field_number  = res_r.field_number;
  assign out_res.field_char    = res_r.field_char;
  assign out_res.char_valid    = res_r.char_valid;
  assign out_res.field_done    = res_r.field_done;
  assign out_res.checksum_part = res_r.checksum_part;
  assign out_res.sentence_done = res_r.sentence_done;
  assign out_res.too_long      = res_r.too_long;

  a_done_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.sentence_done |-> res_r.sentence_kind != KIND_NONE)
    else $error("sentence end without a recognised kind");

  a_char_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.char_valid && (res_r.field_done || res_r.sentence_done)))
    else $error("data character and field end in one result");

  a_field_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.field_number <= FIELD_W'(FIELD_CAP))
    else $error("field number beyond its bound");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(byte_r))
    else $error("stalled input byte lost");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsfs_pkg::*;

  localparam int SINK_HOLD_CYCLES = 64;
  localparam int RANDOM_BYTES     = 400;

  // Indexed by kind_t
  localparam logic [HDR_W-1:0] TALKER_TAB [6] = '{"GPGGA", "GPGLL", "GPGSA",
                                                  "GPGSV", "GPVTG", "GPRMC"};

  localparam res_t IDLE_RES = '{sentence_kind: KIND_NONE, default: '0};
  localparam res_t RMC_HDR  = '{sentence_kind: KIND_RMC, default: '0};
  localparam res_t GSV_HDR  = '{sentence_kind: KIND_GSV, default: '0};
  localparam res_t VTG_HDR  = '{sentence_kind: KIND_VTG, default: '0};
  localparam res_t VTG_END  = '{sentence_kind: KIND_VTG, field_number: 5'd1,
                                sentence_done: 1'b1, default: '0};

  typedef enum {
    LINE_GOOD, LINE_LONG, LINE_MANY, LINE_BAD_HDR, LINE_NO_COMMA,
    LINE_CUT_HDR, LINE_ABANDON, LINE_NOISE
  } line_kind_t;

  typedef enum {TAIL_CHECKSUM, TAIL_CRLF, TAIL_LF, TAIL_CR_TWICE} tail_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  nsfs_byte_if  in_rx ();
  nsfs_field_if out_res ();

  nmea_sentence_field_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rx  (in_rx),
    .out_res(out_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Splitter state as the predictor sees it
  phase_t             sp_phase   = PH_IDLE;
  logic [POS_W-1:0]   sp_hpos    = '0;
  logic [HDR_W-1:0]   sp_letters = '0;
  kind_t              sp_kind    = KIND_NONE;
  logic [FIELD_W-1:0] sp_field   = '0;
  logic [LEN_W-1:0]   sp_len     = '0;
  logic               sp_over    = 1'b0;

  res_t       pending_fields [$];
  logic [7:0] line_q [$];
  int         mismatch_count = 0;
  bit         steady         = 1'b0;
  bit         sink_hold_req  = 1'b0;

  dir_row_t dir_tab [$] = '{
    '{8'h00, 1'b1, IDLE_RES},
    '{CH_DOLLAR, 1'b1, IDLE_RES},
    '{"G", 1'b0, IDLE_RES},
    '{"P", 1'b0, IDLE_RES},
    '{"R", 1'b0, IDLE_RES},
    '{"M", 1'b0, IDLE_RES},
    '{"C", 1'b1, RMC_HDR},
    '{CH_COMMA, 1'b1, RMC_HDR},
    '{8'hFF, 1'b0, IDLE_RES},
    '{CH_COMMA, 1'b0, IDLE_RES},
    '{CH_STAR, 1'b0, IDLE_RES},
    '{CH_COMMA, 1'b0, IDLE_RES},
    '{CH_CR, 1'b0, IDLE_RES},
    '{"7", 1'b0, IDLE_RES},
    '{CH_CR, 1'b0, IDLE_RES},
    '{CH_LF, 1'b0, IDLE_RES},
    '{CH_DOLLAR, 1'b1, IDLE_RES},
    '{"G", 1'b0, IDLE_RES},
    '{"P", 1'b0, IDLE_RES},
    '{"G", 1'b0, IDLE_RES},
    '{"S", 1'b0, IDLE_RES},
    '{"V", 1'b1, GSV_HDR},
    '{CH_COMMA, 1'b0, IDLE_RES},
    '{"5", 1'b0, IDLE_RES},
    '{CH_DOLLAR, 1'b1, IDLE_RES},
    '{"G", 1'b0, IDLE_RES},
    '{"P", 1'b0, IDLE_RES},
    '{"V", 1'b0, IDLE_RES},
    '{"T", 1'b0, IDLE_RES},
    '{"G", 1'b1, VTG_HDR},
    '{CH_COMMA, 1'b0, IDLE_RES},
    '{CH_LF, 1'b1, VTG_END},
    '{CH_DOLLAR, 1'b1, IDLE_RES},
    '{"G", 1'b0, IDLE_RES},
    '{"P", 1'b0, IDLE_RES},
    '{CH_CR, 1'b1, IDLE_RES},
    '{CH_DOLLAR, 1'b1, IDLE_RES},
    '{"G", 1'b0, IDLE_RES},
    '{"P", 1'b0, IDLE_RES},
    '{"X", 1'b0, IDLE_RES},
    '{"T", 1'b0, IDLE_RES},
    '{"G", 1'b1, IDLE_RES},
    '{CH_COMMA, 1'b1, IDLE_RES}
  };

  // Advance the predicted parser by one byte and return the field record it yields
  function automatic res_t split_byte(input logic [7:0] b);
    res_t r;
    logic term;
    r    = IDLE_RES;
    term = (b == CH_CR) || (b == CH_LF);
    if (b == CH_DOLLAR) begin
      sp_phase   = PH_HEADER;
      sp_hpos    = '0;
      sp_letters = '0;
      sp_kind    = KIND_NONE;
      sp_field   = '0;
      sp_len     = LEN_W'(1);
      sp_over    = 1'b0;
    end else if (sp_phase != PH_IDLE) begin
      if (!term && int'(sp_len) >= MAX_SENTENCE_LEN) begin
        // drop the byte, flag the sentence
        sp_over = 1'b1;
        if (sp_phase == PH_BODY || sp_phase == PH_CHECK) begin
          r.sentence_kind = sp_kind;
          r.field_number  = sp_field;
          r.checksum_part = (sp_phase == PH_CHECK);
          r.too_long      = 1'b1;
        end
      end else begin
        if (!term && sp_len < 8'd255) begin
          sp_len = sp_len + 8'd1;
        end
        if (sp_phase == PH_HEADER) begin
          if (term) begin
            sp_phase = PH_IDLE;
          end else begin
            sp_letters = {sp_letters[HDR_W-9:0], b};
            sp_hpos    = sp_hpos + 3'd1;
            if (sp_hpos >= 3'd5) begin
              sp_hpos  = 3'd5;
              sp_phase = PH_IDLE;
              for (int k = 0; k < 6; k++) begin
                if (sp_letters == TALKER_TAB[k]) begin
                  sp_kind  = kind_t'(k);
                  sp_phase = PH_BODY;
                  sp_field = '0;
                end
              end
              r.sentence_kind = sp_kind;
            end
          end
        end else if (sp_phase == PH_BODY && sp_field == '0) begin
          if (b == CH_COMMA) begin
            r.sentence_kind = sp_kind;
            r.too_long      = sp_over;
            sp_field        = FIELD_W'(1);
          end else begin
            sp_kind  = KIND_NONE;
            sp_phase = PH_IDLE;
          end
        end else begin
          r.sentence_kind = sp_kind;
          r.field_number  = sp_field;
          r.too_long      = sp_over;
          if (sp_phase == PH_CHECK && b != CH_LF) begin
            r.checksum_part = 1'b1;
          end
          if (b == CH_LF) begin
            r.sentence_done = 1'b1;
            sp_phase        = PH_IDLE;
            sp_kind         = KIND_NONE;
          end else if (b == CH_CR) begin
            r.field_done = 1'b1;
          end else if (sp_phase == PH_BODY && (b == CH_COMMA || b == CH_STAR)) begin
            r.field_done = 1'b1;
            if (int'(sp_field) < FIELD_CAP) begin
              sp_field = sp_field + FIELD_W'(1);
            end else begin
              sp_field = FIELD_W'(FIELD_CAP);
            end
            if (b == CH_STAR) begin
              sp_phase = PH_CHECK;
            end
          end else begin
            r.char_valid = 1'b1;
            r.field_char = b;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] data_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) begin
      c = 8'h30 + 8'($urandom_range(0, 9));
    end else begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (c == CH_DOLLAR || c == CH_COMMA || c == CH_STAR ||
                 c == CH_CR || c == CH_LF);
    end
    return c;
  endfunction

  task automatic add_header(input int k);
    for (int i = 0; i < 5; i++) begin
      line_q.push_back(TALKER_TAB[k][8*(4-i) +: 8]);
    end
  endtask

  // Each field is led by its comma; the first one is the header comma
  task automatic add_fields(input int count, input int lo, input int hi);
    int len;
    for (int f = 0; f < count; f++) begin
      line_q.push_back(CH_COMMA);
      len = $urandom_range(lo, hi);
      repeat (len) line_q.push_back(data_char());
    end
  endtask

  task automatic add_tail();
    tail_t tail;
    int    n;
    tail = tail_t'($urandom_range(0, 3));
    case (tail)
      TAIL_CHECKSUM: begin
        line_q.push_back(CH_STAR);
        repeat (2) begin
          n = $urandom_range(0, 17);
          if (n == 16) begin
            line_q.push_back(CH_COMMA);
          end else if (n == 17) begin
            line_q.push_back(CH_STAR);
          end else begin
            line_q.push_back((n < 10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n));
          end
        end
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
      end
      TAIL_CRLF: begin
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
      end
      TAIL_LF: begin
        line_q.push_back(CH_LF);
      end
      default: begin
        line_q.push_back(CH_CR);
        line_q.push_back(data_char());
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
      end
    endcase
  endtask

  // Offer one byte, hold it until the transfer, then log what it must yield
  task automatic push_byte(input logic [7:0] b, input bit typed, input res_t want);
    int   gap;
    res_t guess;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_rx.valid   <= 1'b1;
    in_rx.rx_byte <= b;
    do @(posedge clk); while (!in_rx.ready);
    guess = split_byte(b);
    pending_fields.push_back(typed ? want : guess);
  endtask

  task automatic wait_drained();
    in_rx.valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
  endtask

  initial begin : byte_source
    int         idx;
    int         sent;
    int         r;
    int         k;
    int         n;
    line_kind_t cat;
    in_rx.valid   <= 1'b0;
    in_rx.rx_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      push_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);
    end
    wait_drained();

    idx  = 0;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (idx == 0 || (r >= 58 && r < 66)) begin
        cat = LINE_LONG;
      end else if (idx == 1 || (r >= 66 && r < 72)) begin
        cat = LINE_MANY;
      end else if (r < 58) begin
        cat = LINE_GOOD;
      end else if (r < 78) begin
        cat = LINE_BAD_HDR;
      end else if (r < 83) begin
        cat = LINE_NO_COMMA;
      end else if (r < 88) begin
        cat = LINE_CUT_HDR;
      end else if (r < 94) begin
        cat = LINE_ABANDON;
      end else begin
        cat = LINE_NOISE;
      end

      line_q.delete();
      k = $urandom_range(0, 5);
      if (cat != LINE_NOISE) begin
        line_q.push_back(CH_DOLLAR);
      end
      case (cat)
        LINE_GOOD: begin
          add_header(k);
          add_fields($urandom_range(1, 10), 0, 6);
          add_tail();
        end
        LINE_LONG: begin
          add_header(k);
          add_fields($urandom_range(18, 24), 6, 9);
          add_tail();
        end
        LINE_MANY: begin
          add_header(k);
          add_fields($urandom_range(33, 40), 0, 1);
          add_tail();
        end
        LINE_BAD_HDR: begin
          add_header(k);
          line_q[1 + $urandom_range(0, 4)] = 8'h41 + 8'($urandom_range(0, 25));
          add_fields($urandom_range(1, 4), 0, 4);
          add_tail();
        end
        LINE_NO_COMMA: begin
          add_header(k);
          line_q.push_back(data_char());
          add_fields($urandom_range(1, 3), 0, 3);
          add_tail();
        end
        LINE_CUT_HDR: begin
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) begin
            line_q.push_back(TALKER_TAB[k][8*(4-i) +: 8]);
          end
          line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
          add_fields($urandom_range(0, 2), 0, 3);
        end
        LINE_ABANDON: begin
          add_header(k);
          add_fields($urandom_range(1, 5), 0, 5);
        end
        default: begin
          repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase

      // Runs of lines without idling; one of them meets a long sink hold-off
      steady = ((idx / 5) % 3 == 2) || idx == 3;
      if (idx == 3) begin
        sink_hold_req = 1'b1;
      end
      foreach (line_q[i]) begin
        push_byte(line_q[i], 1'b0, IDLE_RES);
      end
      if (cat != LINE_NOISE) begin
        sent += line_q.size();
      end
      if (idx % 7 == 6) begin
        wait_drained();
      end
      idx++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    out_res.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_res.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!out_res.valid);
    end
  end

  always @(posedge clk) begin : field_check
    res_t got;
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.sentence_kind = out_res.sentence_kind;
      got.field_number  = out_res.field_number;
      got.field_char    = out_res.field_char;
      got.char_valid    = out_res.char_valid;
      got.field_done    = out_res.field_done;
      got.checksum_part = out_res.checksum_part;
      got.sentence_done = out_res.sentence_done;
      got.too_long      = out_res.too_long;
      if (pending_fields.size() == 0) begin
        $error("result transfer with nothing pending: kind %0d field %0d char %0h",
               got.sentence_kind, got.field_number, got.field_char);
        mismatch_count++;
      end else begin
        want = pending_fields.pop_front();
        if (got.sentence_kind !== want.sentence_kind) begin
          $error("sentence_kind: expected %0d, got %0d", want.sentence_kind,
                 got.sentence_kind);
          mismatch_count++;
        end
        if (got.field_number !== want.field_number) begin
          $error("field_number: expected %0d, got %0d", want.field_number,
                 got.field_number);
          mismatch_count++;
        end
        if (got.field_char !== want.field_char) begin
          $error("field_char: expected %0h, got %0h", want.field_char, got.field_char);
          mismatch_count++;
        end
        if (got.char_valid !== want.char_valid) begin
          $error("char_valid: expected %0b, got %0b", want.char_valid, got.char_valid);
          mismatch_count++;
        end
        if (got.field_done !== want.field_done) begin
          $error("field_done: expected %0b, got %0b", want.field_done, got.field_done);
          mismatch_count++;
        end
        if (got.checksum_part !== want.checksum_part) begin
          $error("checksum_part: expected %0b, got %0b", want.checksum_part,
                 got.checksum_part);
          mismatch_count++;
        end
        if (got.sentence_done !== want.sentence_done) begin
          $error("sentence_done: expected %0b, got %0b", want.sentence_done,
                 got.sentence_done);
          mismatch_count++;
        end
        if (got.too_long !== want.too_long) begin
          $error("too_long: expected %0b, got %0b", want.too_long, got.too_long);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
